// ===== hdl/psgdp_pkg.sv =====
// Shared types and constants for the sound register dump parser.
`timescale 1ns / 1ps
`default_nettype none

package psgdp_pkg;

    // Parser phases
    typedef enum logic [2:0] {
        PH_HEADER = 3'd0,
        PH_SKIP   = 3'd1,
        PH_CMD    = 3'd2,
        PH_VALUE  = 3'd3,
        PH_COUNT  = 3'd4
    } phase_t;

    // Result kinds
    typedef enum logic [2:0] {
        EV_HDR_OK  = 3'd0,
        EV_HDR_BAD = 3'd1,
        EV_WRITE   = 3'd2,
        EV_FRAME   = 3'd3,
        EV_END     = 3'd4,
        EV_TRUNC   = 3'd5
    } event_kind_t;

    localparam int unsigned POS_W       = 4;
    localparam logic [7:0]  BYTE_FRAME  = 8'hFF;
    localparam logic [7:0]  BYTE_REPEAT = 8'hFE;
    localparam logic [7:0]  NUM_REGS    = 8'd14;
    localparam logic [POS_W-1:0] POS_VERSION = 4'd4;
    localparam logic [POS_W-1:0] POS_RATE    = 4'd5;
    localparam logic [POS_W-1:0] MAGIC_LEN   = 4'd4;
    localparam logic [13:0] DEFAULT_RATE = 14'd50;

    // Result queue sizing
    localparam int unsigned FIFO_DEPTH = 4;
    localparam int unsigned FIFO_PTR_W = 2;
    localparam int unsigned FIFO_CNT_W = 3;

    // One result item
    typedef struct packed {
        event_kind_t kind;
        logic [3:0]  reg_index;
        logic [7:0]  reg_value;
        logic [9:0]  extra_frames;
        logic [7:0]  file_version;
        logic [13:0] play_rate;
        logic        last_of_run;
    } result_t;

    // Results produced by one input byte (slot 1 only when count is 2)
    typedef struct packed {
        logic [1:0] count;
        result_t    slot0;
        result_t    slot1;
    } emit_t;

    // Header magic "PSG" 0x1A
    function automatic logic [7:0] magic_byte(input logic [1:0] pos);
        logic [7:0] m;
        case (pos)
            2'd0:    m = 8'h50;
            2'd1:    m = 8'h53;
            2'd2:    m = 8'h47;
            default: m = 8'h1A;
        endcase
        return m;
    endfunction

    // Plain result of a given kind, all other fields zero
    function automatic result_t plain_result(input event_kind_t k);
        result_t r;
        r = '0;
        r.kind = k;
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/psg_register_dump_parser_core.sv =====
// Top level of the sound register dump parser.
//
// Input stream: one dump byte per transaction on s_tdata, s_tlast on the
// final byte of a dump. Output stream: one parse event per transaction,
// event kind on m_tuser, its fields on m_tdata, m_tlast on the last event
// caused by one input byte.
// Each accepted byte is decoded in the same cycle against the parser state
// and its results (none, one or two) are written into a four-entry result
// queue; the first event reaches the outputs from the queue's entry registers.
// Throughput is one byte per cycle while s_tready is high; a byte may yield
// two events (a stream end after another event). The queue drains at one
// event per cycle with m_tready high; s_tready drops while it holds three or more.
// s_tready depends only on the queue fill, never on m_tready directly.
// When the receiver stalls, events wait in the queue and input is held off
// once the queue cannot take another pair.
// Reset clears the parser to the header phase at position zero and empties
// the queue. After every final byte the parser returns to the header phase.
`timescale 1ns / 1ps
`default_nettype none

module psg_register_dump_parser_core #(
    parameter int unsigned HEADER_BYTES = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
    input  wire logic        s_tlast,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [47:0]      m_tdata,   // [3:0] reg_index, [11:4] reg_value,
                                        // [21:12] extra_frames, [29:22] file_version,
                                        // [43:30] play_rate, [47:44] zero
    output logic [2:0]       m_tuser,   // [2:0] event_kind
    output logic             m_tlast
);

    psgdp_pkg::emit_t    emit;
    psgdp_pkg::result_t  head;
    logic                accept;
    logic                space;

    assign s_tready = space;
    assign accept   = s_tvalid && space;

    // Byte decode and parser state
    psgdp_parser #(
        .HEADER_BYTES (HEADER_BYTES)
    ) u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .data_byte (s_tdata),
        .last_byte (s_tlast),
        .emit      (emit)
    );

    // Result queue
    psgdp_result_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .emit      (emit),
        .space     (space),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_item  (head)
    );

    // Output packing
    assign m_tdata = {4'b0000, head.play_rate, head.file_version, head.extra_frames,
                      head.reg_value, head.reg_index};
    assign m_tuser = head.kind;
    assign m_tlast = head.last_of_run;

endmodule

`default_nettype wire

// ===== hdl/psgdp_parser.sv =====
// Byte parser: header check, body decode and parser state registers.
`timescale 1ns / 1ps
`default_nettype none

module psgdp_parser #(
    parameter int unsigned HEADER_BYTES = 16
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             accept,
    input  wire logic [7:0]       data_byte,
    input  wire logic             last_byte,
    output psgdp_pkg::emit_t      emit
);

    localparam logic [psgdp_pkg::POS_W-1:0] HDR_LAST = psgdp_pkg::POS_W'(HEADER_BYTES - 1);

    psgdp_pkg::phase_t              phase_reg, phase_next;
    logic [psgdp_pkg::POS_W-1:0]    pos_reg, pos_next;
    logic [7:0]                     pending_reg, pending_next;
    logic [7:0]                     version_reg, version_next;
    logic [7:0]                     rate_reg, rate_next;

    logic                           first_valid;
    psgdp_pkg::result_t             first;
    logic                           end_flag;
    logic                           magic_bad;
    logic [13:0]                    rate_wide;
    logic [13:0]                    rate_hz;

    // Rate byte times 50 as shift-and-add
    always_comb
    begin
        rate_wide = (14'(rate_next) << 5) + (14'(rate_next) << 4) + (14'(rate_next) << 1);
        rate_hz   = (rate_next == 8'd0) ? psgdp_pkg::DEFAULT_RATE : rate_wide;
    end

    assign magic_bad = (pos_reg < psgdp_pkg::MAGIC_LEN)
                    && (data_byte != psgdp_pkg::magic_byte(pos_reg[1:0]));

    // Next state and results of the current byte
    always_comb
    begin
        phase_next   = phase_reg;
        pos_next     = pos_reg;
        pending_next = pending_reg;
        version_next = version_reg;
        rate_next    = rate_reg;
        first_valid  = 1'b0;
        first        = psgdp_pkg::plain_result(psgdp_pkg::EV_END);
        end_flag     = 1'b0;

        unique case (phase_reg)
            psgdp_pkg::PH_SKIP:
            begin
                // drop everything up to the stream's last byte
            end
            psgdp_pkg::PH_CMD:
            begin
                end_flag = last_byte;
                if (data_byte == psgdp_pkg::BYTE_FRAME) begin
                    first_valid = 1'b1;
                    first       = psgdp_pkg::plain_result(psgdp_pkg::EV_FRAME);
                end else if (data_byte == psgdp_pkg::BYTE_REPEAT) begin
                    if (last_byte) begin
                        first_valid = 1'b1;
                        first       = psgdp_pkg::plain_result(psgdp_pkg::EV_FRAME);
                    end else begin
                        phase_next = psgdp_pkg::PH_COUNT;
                    end
                end else begin
                    pending_next = data_byte;
                    if (last_byte) begin
                        first_valid = 1'b1;
                        first       = psgdp_pkg::plain_result(psgdp_pkg::EV_TRUNC);
                    end else begin
                        phase_next = psgdp_pkg::PH_VALUE;
                    end
                end
            end
            psgdp_pkg::PH_VALUE:
            begin
                end_flag   = last_byte;
                phase_next = psgdp_pkg::PH_CMD;
                if (pending_reg < psgdp_pkg::NUM_REGS) begin
                    first_valid     = 1'b1;
                    first           = psgdp_pkg::plain_result(psgdp_pkg::EV_WRITE);
                    first.reg_index = pending_reg[3:0];
                    first.reg_value = data_byte;
                end
            end
            psgdp_pkg::PH_COUNT:
            begin
                end_flag           = last_byte;
                phase_next         = psgdp_pkg::PH_CMD;
                first_valid        = 1'b1;
                first              = psgdp_pkg::plain_result(psgdp_pkg::EV_FRAME);
                first.extra_frames = {data_byte, 2'b00};
            end
            default:
            begin
                // header phase
                if (pos_reg == psgdp_pkg::POS_VERSION) begin
                    version_next = data_byte;
                end
                if (pos_reg == psgdp_pkg::POS_RATE) begin
                    rate_next = data_byte;
                end
                if (magic_bad) begin
                    first_valid = 1'b1;
                    first       = psgdp_pkg::plain_result(psgdp_pkg::EV_HDR_BAD);
                    phase_next  = psgdp_pkg::PH_SKIP;
                end else if (pos_reg >= HDR_LAST) begin
                    first_valid         = 1'b1;
                    first               = psgdp_pkg::plain_result(psgdp_pkg::EV_HDR_OK);
                    first.file_version  = version_next;
                    first.play_rate     = rate_hz;
                    phase_next          = psgdp_pkg::PH_CMD;
                    end_flag            = last_byte;
                end else if (last_byte) begin
                    first_valid = 1'b1;
                    first       = psgdp_pkg::plain_result(psgdp_pkg::EV_HDR_BAD);
                end else begin
                    pos_next = pos_reg + 1'b1;
                end
            end
        endcase

        // any last byte restarts at the header
        if (last_byte) begin
            phase_next = psgdp_pkg::PH_HEADER;
            pos_next   = '0;
        end
    end

    // Pack the byte's results into slots, marking the final one
    always_comb
    begin
        emit.count = {1'b0, first_valid} + {1'b0, end_flag};
        emit.slot0 = first_valid ? first : psgdp_pkg::plain_result(psgdp_pkg::EV_END);
        emit.slot0.last_of_run = !(first_valid && end_flag);
        emit.slot1 = psgdp_pkg::plain_result(psgdp_pkg::EV_END);
        emit.slot1.last_of_run = 1'b1;
    end

    // Parser state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg   <= psgdp_pkg::PH_HEADER;
            pos_reg     <= '0;
            pending_reg <= '0;
            version_reg <= '0;
            rate_reg    <= '0;
        end else if (accept) begin
            phase_reg   <= phase_next;
            pos_reg     <= pos_next;
            pending_reg <= pending_next;
            version_reg <= version_next;
            rate_reg    <= rate_next;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/psgdp_result_fifo.sv =====
// Small result queue: takes up to two results per cycle, hands out one.
`timescale 1ns / 1ps
`default_nettype none

module psgdp_result_fifo (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    input  wire psgdp_pkg::emit_t   emit,
    output logic                    space,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output psgdp_pkg::result_t      out_item
);

    psgdp_pkg::result_t                 entry_reg [psgdp_pkg::FIFO_DEPTH];
    logic [psgdp_pkg::FIFO_PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [psgdp_pkg::FIFO_PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [psgdp_pkg::FIFO_CNT_W-1:0]   count_reg, count_next;
    logic [psgdp_pkg::FIFO_PTR_W-1:0]   wr_ptr_plus1;
    logic [1:0]                         n_push;
    logic                               pop;

    // Room for a worst-case pair of results
    assign space        = count_reg <= psgdp_pkg::FIFO_CNT_W'(psgdp_pkg::FIFO_DEPTH - 2);
    assign out_valid    = count_reg != '0;
    assign out_item     = entry_reg[rd_ptr_reg];
    assign pop          = out_valid && out_ready;
    assign n_push       = push ? emit.count : 2'd0;
    assign wr_ptr_plus1 = wr_ptr_reg + 1'b1;

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + psgdp_pkg::FIFO_PTR_W'(n_push);
        rd_ptr_next = rd_ptr_reg + psgdp_pkg::FIFO_PTR_W'(pop);
        count_next  = count_reg + psgdp_pkg::FIFO_CNT_W'(n_push)
                    - psgdp_pkg::FIFO_CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (n_push != 2'd0) begin
            entry_reg[wr_ptr_reg] <= emit.slot0;
        end
        if (n_push == 2'd2) begin
            entry_reg[wr_ptr_plus1] <= emit.slot1;
        end
    end

endmodule

`default_nettype wire
